### rtl/exrm_pkg.sv
// Package for the XYZ Euler angle to rotation matrix block.
// Holds the rotator widths, arctangent constants, lane record and entry indexes.
// No dependencies; used by every module of the block.
package exrm_pkg;

  // default angle width (a full turn is 2**ANGLE_BITS) and fraction width of results
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;

  // rotator: 31 steps, angles at 2**32 units per turn, vectors in Q30
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int CW           = 34;  // vector component width
  localparam int ZW           = 34;  // residual angle width

  // atan(2**-i) in units of 2**32 per turn
  localparam int ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  // axis lanes
  localparam int NUM_AXES  = 3;
  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW   = 2;

  // matrix entries, row major
  localparam int NUM_ENTRIES = 9;
  localparam int IDX_R00 = 0;
  localparam int IDX_R01 = 1;
  localparam int IDX_R02 = 2;
  localparam int IDX_R10 = 3;
  localparam int IDX_R11 = 4;
  localparam int IDX_R12 = 5;
  localparam int IDX_R20 = 6;
  localparam int IDX_R21 = 7;
  localparam int IDX_R22 = 8;

  // one rotator lane as it travels down the chain
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } lane_t;

endpackage

### rtl/exrm_cell.sv
// One rotator cell: a single micro-rotation step for all three axis lanes.
// Depends on exrm_pkg for the lane record and the arctangent constants.
module exrm_cell #(
  parameter int STEP = 0
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  exrm_pkg::lane_t [exrm_pkg::NUM_AXES-1:0]    d,
  output logic                                        out_valid,
  output exrm_pkg::lane_t [exrm_pkg::NUM_AXES-1:0]    q
);

  localparam logic signed [exrm_pkg::ZW-1:0] ATAN =
    exrm_pkg::ZW'(exrm_pkg::ATAN_TURNS[STEP]);

  exrm_pkg::lane_t [exrm_pkg::NUM_AXES-1:0] q_next;

  // rotate toward zero residual angle
  always_comb begin
    for (int k = 0; k < exrm_pkg::NUM_AXES; k++) begin
      q_next[k].flip = d[k].flip;
      if (d[k].z >= 0) begin
        q_next[k].x = d[k].x - (d[k].y >>> STEP);
        q_next[k].y = d[k].y + (d[k].x >>> STEP);
        q_next[k].z = d[k].z - ATAN;
      end else begin
        q_next[k].x = d[k].x + (d[k].y >>> STEP);
        q_next[k].y = d[k].y - (d[k].x >>> STEP);
        q_next[k].z = d[k].z + ATAN;
      end
    end
  end

  // advance to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

### rtl/exrm_mat.sv
// Matrix stage: turns rotator vectors into sines and cosines, then forms the
// nine rounded, saturated entries over five registered steps. Depends on exrm_pkg.
module exrm_mat #(
  parameter int FRAC_BITS = exrm_pkg::FRAC_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  exrm_pkg::lane_t [exrm_pkg::NUM_AXES-1:0]    d,
  output logic                                        out_valid,
  output logic [exrm_pkg::NUM_ENTRIES-1:0][FRAC_BITS+1:0] ent
);

  localparam int SW     = FRAC_BITS + 2;
  localparam int PW     = 2 * SW;
  localparam int CW     = exrm_pkg::CW;
  localparam int CSHIFT = exrm_pkg::CORDIC_FRAC - FRAC_BITS;

  localparam logic signed [CW-1:0] CHALF = CW'((64'sd1 <<< CSHIFT) >>> 1);
  localparam logic signed [CW-1:0] CONE  = CW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [PW:0]   PHALF = (PW+1)'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [PW:0]   PONE  = (PW+1)'(64'sd1 <<< FRAC_BITS);

  localparam int ROLL  = exrm_pkg::AXIS_ROLL;
  localparam int PITCH = exrm_pkg::AXIS_PITCH;
  localparam int YAW   = exrm_pkg::AXIS_YAW;

  // round half-up a Q30 component to Q1.FRAC_BITS and clamp to +-1
  function automatic logic signed [SW-1:0] sat_c(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CHALF) >>> CSHIFT;
    if (r > CONE) begin
      sat_c = SW'(CONE);
    end else if (r < -CONE) begin
      sat_c = SW'(-CONE);
    end else begin
      sat_c = SW'(r);
    end
  endfunction

  // round half-up an exact product sum to Q1.FRAC_BITS and clamp to +-1
  function automatic logic signed [SW-1:0] to_q(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + PHALF) >>> FRAC_BITS;
    if (r > PONE) begin
      to_q = SW'(PONE);
    end else if (r < -PONE) begin
      to_q = SW'(-PONE);
    end else begin
      to_q = SW'(r);
    end
  endfunction

  logic [4:0] v;

  // step 0: sine and cosine of each axis
  logic signed [CW-1:0] xf [exrm_pkg::NUM_AXES];
  logic signed [CW-1:0] yf [exrm_pkg::NUM_AXES];
  logic signed [SW-1:0] c [exrm_pkg::NUM_AXES];
  logic signed [SW-1:0] s [exrm_pkg::NUM_AXES];

  always_comb begin
    for (int k = 0; k < exrm_pkg::NUM_AXES; k++) begin
      xf[k] = d[k].flip ? -d[k].x : d[k].x;
      yf[k] = d[k].flip ? -d[k].y : d[k].y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < exrm_pkg::NUM_AXES; k++) begin
        c[k] <= sat_c(xf[k]);
        s[k] <= sat_c(yf[k]);
      end
    end
  end

  // step 1: first layer of products
  logic signed [PW-1:0] p_c2c3, p_c2s3, p_c2s1, p_c1c2, p_c3s2, p_s2s3;
  logic signed [PW-1:0] p_c1s3, p_s1s3, p_c1c3, p_c3s1;
  logic signed [SW-1:0] c1_a, s1_a, s2_a;

  always_ff @(posedge clk) begin
    if (en) begin
      p_c2c3 <= c[PITCH] * c[YAW];
      p_c2s3 <= c[PITCH] * s[YAW];
      p_c2s1 <= c[PITCH] * s[ROLL];
      p_c1c2 <= c[ROLL] * c[PITCH];
      p_c3s2 <= c[YAW] * s[PITCH];
      p_s2s3 <= s[PITCH] * s[YAW];
      p_c1s3 <= c[ROLL] * s[YAW];
      p_s1s3 <= s[ROLL] * s[YAW];
      p_c1c3 <= c[ROLL] * c[YAW];
      p_c3s1 <= c[YAW] * s[ROLL];
      c1_a   <= c[ROLL];
      s1_a   <= s[ROLL];
      s2_a   <= s[PITCH];
    end
  end

  // step 2: round the shared terms t and u
  logic signed [SW-1:0] t, u, c1_b, s1_b, s2_b;
  logic signed [PW-1:0] b_c2c3, b_c2s3, b_c2s1, b_c1c2;
  logic signed [PW-1:0] b_c1s3, b_s1s3, b_c1c3, b_c3s1;

  always_ff @(posedge clk) begin
    if (en) begin
      t      <= to_q((PW+1)'(p_c3s2));
      u      <= to_q((PW+1)'(p_s2s3));
      c1_b   <= c1_a;
      s1_b   <= s1_a;
      s2_b   <= s2_a;
      b_c2c3 <= p_c2c3;
      b_c2s3 <= p_c2s3;
      b_c2s1 <= p_c2s1;
      b_c1c2 <= p_c1c2;
      b_c1s3 <= p_c1s3;
      b_s1s3 <= p_s1s3;
      b_c1c3 <= p_c1c3;
      b_c3s1 <= p_c3s1;
    end
  end

  // step 3: second layer of products against t and u
  logic signed [PW-1:0] p_s1t, p_c1t, p_s1u, p_c1u;
  logic signed [PW-1:0] e_c2c3, e_c2s3, e_c2s1, e_c1c2;
  logic signed [PW-1:0] e_c1s3, e_s1s3, e_c1c3, e_c3s1;
  logic signed [SW-1:0] s2_e;

  always_ff @(posedge clk) begin
    if (en) begin
      p_s1t  <= s1_b * t;
      p_c1t  <= c1_b * t;
      p_s1u  <= s1_b * u;
      p_c1u  <= c1_b * u;
      s2_e   <= s2_b;
      e_c2c3 <= b_c2c3;
      e_c2s3 <= b_c2s3;
      e_c2s1 <= b_c2s1;
      e_c1c2 <= b_c1c2;
      e_c1s3 <= b_c1s3;
      e_s1s3 <= b_s1s3;
      e_c1c3 <= b_c1c3;
      e_c3s1 <= b_c3s1;
    end
  end

  // step 4: combine, round and clamp the entries; R02 passes the pitch sine through
  always_ff @(posedge clk) begin
    if (en) begin
      ent[exrm_pkg::IDX_R00] <= to_q((PW+1)'(e_c2c3));
      ent[exrm_pkg::IDX_R01] <= to_q(-(PW+1)'(e_c2s3));
      ent[exrm_pkg::IDX_R02] <= s2_e;
      ent[exrm_pkg::IDX_R10] <= to_q((PW+1)'(e_c1s3) + (PW+1)'(p_s1t));
      ent[exrm_pkg::IDX_R11] <= to_q((PW+1)'(e_c1c3) - (PW+1)'(p_s1u));
      ent[exrm_pkg::IDX_R12] <= to_q(-(PW+1)'(e_c2s1));
      ent[exrm_pkg::IDX_R20] <= to_q((PW+1)'(e_s1s3) - (PW+1)'(p_c1t));
      ent[exrm_pkg::IDX_R21] <= to_q((PW+1)'(p_c1u) + (PW+1)'(e_c3s1));
      ent[exrm_pkg::IDX_R22] <= to_q((PW+1)'(e_c1c2));
    end
  end

  // advance the valid marks alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  assign out_valid = v[4];

endmodule

### rtl/euler_xyz_to_rotation_matrix_top.sv
// XYZ Euler angles (roll, pitch, yaw) to 3x3 rotation matrix, fixed point.
// Usage:
//   Input channel in_valid/in_stall carries one request of three binary angles
//   (2**ANGLE_BITS per turn). A request is taken at a clock edge with in_valid
//   high and in_stall low. Output channel out_valid/out_stall carries the nine
//   entries r00..r22 in signed Q1.FRAC_BITS, clamped to +-1.0.
// Path: one input register, a chain of 31 rotator cells (one micro-rotation
//   each, all three axes side by side), and five matrix steps feeding an
//   output register.
// Throughput: one request per cycle; the chain holds while skid_valid is set.
// Stall: a result waiting in the output register does not block the chain; the
//   next result goes to a skid register, and only when that is full does the
//   whole chain hold and in_stall rise. in_stall is a registered signal.
// Reset: synchronous, active high; clears every valid mark, so the block
//   comes out empty and accepts at once.
// Depends on exrm_pkg, exrm_cell and exrm_mat.
module euler_xyz_to_rotation_matrix_top #(
  parameter int ANGLE_BITS = exrm_pkg::ANGLE_BITS,
  parameter int FRAC_BITS  = exrm_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic        [ANGLE_BITS-1:0] roll_angle,
  input  logic        [ANGLE_BITS-1:0] pitch_angle,
  input  logic        [ANGLE_BITS-1:0] yaw_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [FRAC_BITS+1:0]  r00,
  output logic signed [FRAC_BITS+1:0]  r01,
  output logic signed [FRAC_BITS+1:0]  r02,
  output logic signed [FRAC_BITS+1:0]  r10,
  output logic signed [FRAC_BITS+1:0]  r11,
  output logic signed [FRAC_BITS+1:0]  r12,
  output logic signed [FRAC_BITS+1:0]  r20,
  output logic signed [FRAC_BITS+1:0]  r21,
  output logic signed [FRAC_BITS+1:0]  r22
);

  localparam int SW    = FRAC_BITS + 2;
  localparam int NA    = exrm_pkg::NUM_AXES;
  localparam int NE    = exrm_pkg::NUM_ENTRIES;
  localparam int STEPS = exrm_pkg::CORDIC_STEPS;
  localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< FRAC_BITS);

  logic en;
  logic skid_valid;

  // the chain moves unless the skid register is occupied
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // map angles onto 2**32 per turn and fold into the right half plane
  logic [ANGLE_BITS-1:0] ang [NA];
  logic [31:0]           aw  [NA];
  logic                  fl  [NA];
  exrm_pkg::lane_t [NA-1:0] lane_next;

  assign ang[exrm_pkg::AXIS_ROLL]  = roll_angle;
  assign ang[exrm_pkg::AXIS_PITCH] = pitch_angle;
  assign ang[exrm_pkg::AXIS_YAW]   = yaw_angle;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      aw[k]             = 32'(ang[k]) << (32 - ANGLE_BITS);
      fl[k]             = aw[k][31] ^ aw[k][30];
      lane_next[k].flip = fl[k];
      lane_next[k].x    = exrm_pkg::CW'(exrm_pkg::CORDIC_GAIN);
      lane_next[k].y    = '0;
      lane_next[k].z    = exrm_pkg::ZW'($signed({aw[k][31] ^ fl[k], aw[k][30:0]}));
    end
  end

  // input register heads the chain
  exrm_pkg::lane_t [NA-1:0] chain_d [STEPS+1];
  logic                     chain_v [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else if (en) begin
      chain_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_d[0] <= lane_next;
    end
  end

  // row of rotator cells
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    exrm_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_v[i]),
      .d        (chain_d[i]),
      .out_valid(chain_v[i+1]),
      .q        (chain_d[i+1])
    );
  end

  // matrix entries from the finished vectors
  logic                 mat_valid;
  logic [NE-1:0][SW-1:0] mat_ent;

  exrm_mat #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (chain_v[STEPS]),
    .d        (chain_d[STEPS]),
    .out_valid(mat_valid),
    .ent      (mat_ent)
  );

  // output register with a skid register behind it
  logic [NE-1:0][SW-1:0] outd;
  logic [NE-1:0][SW-1:0] skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= mat_valid;
      end
    end else if (mat_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      outd <= skid_valid ? skid : mat_ent;
    end else if (!skid_valid) begin
      skid <= mat_ent;
    end
  end

  assign r00 = outd[exrm_pkg::IDX_R00];
  assign r01 = outd[exrm_pkg::IDX_R01];
  assign r02 = outd[exrm_pkg::IDX_R02];
  assign r10 = outd[exrm_pkg::IDX_R10];
  assign r11 = outd[exrm_pkg::IDX_R11];
  assign r12 = outd[exrm_pkg::IDX_R12];
  assign r20 = outd[exrm_pkg::IDX_R20];
  assign r21 = outd[exrm_pkg::IDX_R21];
  assign r22 = outd[exrm_pkg::IDX_R22];

  // skid register is only occupied while the output register holds a result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // a free output drains the skid register by the next cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid register did not drain");

  // entries r11 and r20 stay within +-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (r11 <= ONE && r11 >= -ONE && r20 <= ONE && r20 >= -ONE))
    else $error("matrix entry out of range");

endmodule
